@@ rtl/dmxut_pkg.sv @@
// Shared types and constants of the DMX512 universe transmitter.
`timescale 1ns / 1ps
`default_nettype none
package dmxut_pkg;

  localparam int CHANNEL_W = 10;
  localparam int VALUE_W   = 8;
  localparam int PERIOD_W  = 16;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 16'd6250;

  // start bit, eight data bits, two stop bits
  localparam logic [3:0] BITS_PER_SLOT = 4'd11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_BAD_WRITE = 2'd1,
    CMD_TICK      = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  // handshake between front and command queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qpush_t;

endpackage
`default_nettype wire

@@ rtl/dmxut_front.sv @@
// Front end: accepts input beats and classifies them into queue commands.
`timescale 1ns / 1ps
`default_nettype none
module dmxut_front #(
  parameter int SLOT_COUNT = 512
) (
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [dmxut_pkg::CHANNEL_W-1:0] channel_i,
  input  wire logic [dmxut_pkg::VALUE_W-1:0]   value_i,
  input  wire logic                            q_full_i,
  input  wire logic                            clearing_i,
  output dmxut_pkg::qpush_t                    qpush_o
);

  logic slot_ok;

  assign slot_ok = (channel_i != '0) &&
                   (channel_i <= dmxut_pkg::CHANNEL_W'(SLOT_COUNT));

  // hold off while the slot memory is being cleared or the queue is full
  assign in_ready_o = !q_full_i && !clearing_i;

  always_comb begin
    qpush_o.push        = in_valid_i && in_ready_o;
    qpush_o.cmd.channel = channel_i;
    qpush_o.cmd.value   = value_i;
    if (mode_i) begin
      qpush_o.cmd.kind = dmxut_pkg::CMD_TICK;
    end else if (slot_ok) begin
      qpush_o.cmd.kind = dmxut_pkg::CMD_WRITE;
    end else begin
      qpush_o.cmd.kind = dmxut_pkg::CMD_BAD_WRITE;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dmxut_queue.sv @@
// Short command queue between front end and sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dmxut_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  dmxut_pkg::qpush_t qpush_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         pop_i,
  output dmxut_pkg::cmd_t   cmd_o
);

  dmxut_pkg::cmd_t                 entry_q [dmxut_pkg::QUEUE_DEPTH];
  logic [dmxut_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [dmxut_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [dmxut_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == dmxut_pkg::QCNT_W'(dmxut_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = qpush_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= qpush_i.cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dmxut_back.sv @@
// Back end: slot memory, frame sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module dmxut_back #(
  parameter int SLOT_COUNT             = 512,
  parameter int BREAK_TICKS            = 23,
  parameter int MARK_AFTER_BREAK_TICKS = 3
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dmxut_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  wire logic                           q_valid_i,
  input  dmxut_pkg::cmd_t                     cmd_i,
  output logic                                pop_o,
  output logic                                clearing_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                line_level_o,
  output logic                                frame_start_o,
  output logic                                write_ignored_o,
  output logic                                busy_res_o
);

  localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SW    = $clog2(SLOT_COUNT + 1);
  localparam int MAXPH = (BREAK_TICKS > MARK_AFTER_BREAK_TICKS) ?
                         BREAK_TICKS : MARK_AFTER_BREAK_TICKS;
  localparam int CW    = $clog2(MAXPH);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_BREAK = 4'b0010,
    PH_MAB   = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    LS_KEEP = 2'd0,
    LS_LOW  = 2'd1,
    LS_HIGH = 2'd2,
    LS_MEM  = 2'd3
  } line_src_e;

  // configuration
  logic [dmxut_pkg::PERIOD_W-1:0] period_q;

  // clearing pass
  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // sequencer state
  phase_e                         phase_q, phase_d, ph_now;
  logic [CW-1:0]                  cnt_q, cnt_d, cnt_now;
  logic [3:0]                     bit_q, bit_d, bit_inc;
  logic [SW-1:0]                  slot_q, slot_d, slot_m1;
  logic [dmxut_pkg::PERIOD_W-1:0] sfs_q, sfs_d, sfs_inc;

  // memory port
  logic [dmxut_pkg::VALUE_W-1:0]   mem_q [SLOT_COUNT];
  logic [dmxut_pkg::VALUE_W-1:0]   rdata_q;
  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_addr;
  logic [dmxut_pkg::VALUE_W-1:0]   mem_wdata;
  logic [dmxut_pkg::CHANNEL_W-1:0] ch_m1;

  // result register
  logic      fire, out_take;
  line_src_e ls_d;
  line_src_e ls_q;
  logic [2:0] bitsel_d, bitsel_q;
  logic       fs_d, fs_q, ign_d, ign_q, busy_d, busy_q;
  logic       out_valid_q, line_last_q;

  assign clearing_o = clr_active_q;
  assign out_take   = out_valid_q && out_ready_i;
  assign fire       = !clr_active_q && q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o      = fire;
  assign ch_m1      = cmd_i.channel - 1'b1;
  assign slot_m1    = slot_q - 1'b1;
  assign bit_inc    = bit_q + 1'b1;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    bit_d        = bit_q;
    slot_d       = slot_q;
    sfs_d        = sfs_q;
    sfs_inc      = sfs_q;
    ph_now       = phase_q;
    cnt_now      = cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = clr_addr_q;
    mem_wdata    = '0;
    ls_d         = LS_KEEP;
    bitsel_d     = '0;
    fs_d         = 1'b0;
    ign_d        = 1'b0;
    busy_d       = 1'b0;

    if (clr_active_q) begin
      // zero one slot a cycle
      mem_we     = 1'b1;
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(SLOT_COUNT - 1)) begin
        clr_active_d = 1'b0;
      end
    end else if (fire) begin
      case (cmd_i.kind)
        dmxut_pkg::CMD_WRITE: begin
          mem_we    = 1'b1;
          mem_addr  = ch_m1[AW-1:0];
          mem_wdata = cmd_i.value;
          busy_d    = (phase_q != PH_IDLE);
        end
        dmxut_pkg::CMD_BAD_WRITE: begin
          ign_d  = 1'b1;
          busy_d = (phase_q != PH_IDLE);
        end
        dmxut_pkg::CMD_TICK: begin
          sfs_inc = (sfs_q != '1) ? sfs_q + 1'b1 : sfs_q;
          sfs_d   = sfs_inc;
          if ((phase_q == PH_IDLE) && (sfs_inc >= period_q)) begin
            ph_now  = PH_BREAK;
            cnt_now = '0;
            sfs_d   = '0;
            fs_d    = 1'b1;
          end
          case (ph_now)
            PH_BREAK: begin
              ls_d   = LS_LOW;
              busy_d = 1'b1;
              if (cnt_now == CW'(BREAK_TICKS - 1)) begin
                phase_d = PH_MAB;
                cnt_d   = '0;
              end else begin
                phase_d = PH_BREAK;
                cnt_d   = cnt_now + 1'b1;
              end
            end
            PH_MAB: begin
              ls_d   = LS_HIGH;
              busy_d = 1'b1;
              if (cnt_now == CW'(MARK_AFTER_BREAK_TICKS - 1)) begin
                phase_d = PH_DATA;
                cnt_d   = '0;
                slot_d  = '0;
                bit_d   = '0;
              end else begin
                cnt_d = cnt_now + 1'b1;
              end
            end
            PH_DATA: begin
              busy_d = 1'b1;
              if (bit_q == 4'd0) begin
                ls_d = LS_LOW;
              end else if (bit_q >= 4'd9) begin
                ls_d = LS_HIGH;
              end else if (slot_q == '0) begin
                // start code is all zero
                ls_d = LS_LOW;
              end else begin
                ls_d     = LS_MEM;
                bitsel_d = 3'(bit_q - 4'd1);
                mem_re   = 1'b1;
                mem_addr = slot_m1[AW-1:0];
              end
              if (bit_inc >= dmxut_pkg::BITS_PER_SLOT) begin
                bit_d = '0;
                if (slot_q == SW'(SLOT_COUNT)) begin
                  slot_d  = '0;
                  phase_d = PH_IDLE;
                end else begin
                  slot_d = slot_q + 1'b1;
                end
              end else begin
                bit_d = bit_inc;
              end
            end
            default: begin
              ls_d = LS_HIGH;
            end
          endcase
        end
        default: begin
          ign_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= dmxut_pkg::FRAME_PERIOD_RESET;
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      phase_q      <= PH_IDLE;
      cnt_q        <= '0;
      bit_q        <= '0;
      slot_q       <= '0;
      sfs_q        <= '1;
      out_valid_q  <= 1'b0;
      line_last_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      bit_q        <= bit_d;
      slot_q       <= slot_d;
      sfs_q        <= sfs_d;
      if (out_take) begin
        line_last_q <= line_level_o;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ls_q     <= ls_d;
      bitsel_q <= bitsel_d;
      fs_q     <= fs_d;
      ign_q    <= ign_d;
      busy_q   <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_comb begin
    case (ls_q)
      LS_LOW:  line_level_o = 1'b0;
      LS_HIGH: line_level_o = 1'b1;
      LS_MEM:  line_level_o = rdata_q[bitsel_q];
      default: line_level_o = line_last_q;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign frame_start_o   = fs_q;
  assign write_ignored_o = ign_q;
  assign busy_res_o      = busy_q;

endmodule
`default_nettype wire

@@ rtl/dmx512_universe_transmitter.sv @@
// Top level of the DMX512 universe transmitter.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  mode_i, channel_i, value_i
//  out      output     out_valid_o/out_ready_i line_level_o, frame_start_o,
//                                             write_ignored_o, busy_res_o
//  cfg      input      cfg_we_i (no wait)     cfg_wdata_i (frame_period_ticks)
//
// One beat is taken per cycle while in_ready_o is high, and one result beat
// leaves per cycle while out_ready_i is high; the single slot memory port is
// used by at most one item per cycle, which sets that rate. A result beat
// passes through the command queue and then the result register before it is
// offered. After reset the slot memory is zeroed one slot a cycle, with
// in_ready_o low; configuration writes are taken during that pass.
// A stalled output holds the sequencer; up to four more beats wait in the
// command queue before in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none
module dmx512_universe_transmitter #(
  parameter int SLOT_COUNT             = 512,
  parameter int BREAK_TICKS            = 23,
  parameter int MARK_AFTER_BREAK_TICKS = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dmxut_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [dmxut_pkg::CHANNEL_W-1:0] channel_i,
  input  wire logic [dmxut_pkg::VALUE_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 line_level_o,
  output logic                                 frame_start_o,
  output logic                                 write_ignored_o,
  output logic                                 busy_res_o
);

  dmxut_pkg::qpush_t qpush;
  dmxut_pkg::cmd_t   q_cmd;
  logic              q_full, q_valid, q_pop, clearing;

  // classify beats: tick, write to a real slot, or write to be dropped
  dmxut_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .channel_i  (channel_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .qpush_o    (qpush)
  );

  // decouple acceptance from result back-pressure
  dmxut_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qpush_i (qpush),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  // run slot writes and line ticks in order; the memory is read on the data
  // bit's own tick, so a write ahead of it in the stream is always seen
  dmxut_back #(
    .SLOT_COUNT             (SLOT_COUNT),
    .BREAK_TICKS            (BREAK_TICKS),
    .MARK_AFTER_BREAK_TICKS (MARK_AFTER_BREAK_TICKS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .cmd_i           (q_cmd),
    .pop_o           (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_level_o    (line_level_o),
    .frame_start_o   (frame_start_o),
    .write_ignored_o (write_ignored_o),
    .busy_res_o      (busy_res_o)
  );

endmodule
`default_nettype wire

@@ test/dmx512_universe_transmitter_tb.sv @@
// Self-checking testbench for the DMX512 universe transmitter top level.
`timescale 1ns / 1ps
module dmx512_universe_transmitter_tb;

  // Geometry of the universe under test; passed to the block explicitly so the
  // line model below and the RTL agree on frame length.
  localparam int SLOTS     = 512;
  localparam int BREAK_LEN = 23;
  localparam int MAB_LEN   = 3;

  // Input item kinds as carried on mode_i.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [dmxut_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam int SINCE_SAT = 65535;

  // Slow enough to leave idle ticks between two frames: a whole frame is
  // break + mark after break + 513 slots of 11 bits = 5669 ticks.
  localparam logic [dmxut_pkg::PERIOD_W-1:0] PERIOD_ABOVE_FRAME = 16'd5690;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BREAK,
    ST_MARK,
    ST_DATA
  } line_phase_e;

  typedef struct packed {
    logic line_level;
    logic frame_start;
    logic write_ignored;
    logic busy;
  } line_result_t;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [dmxut_pkg::PERIOD_W-1:0]  cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic                            mode_i      = MODE_WRITE;
  logic [dmxut_pkg::CHANNEL_W-1:0] channel_i   = '0;
  logic [dmxut_pkg::VALUE_W-1:0]   value_i     = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            line_level_o;
  logic                            frame_start_o;
  logic                            write_ignored_o;
  logic                            busy_res_o;

  dmx512_universe_transmitter #(
    .SLOT_COUNT            (SLOTS),
    .BREAK_TICKS           (BREAK_LEN),
    .MARK_AFTER_BREAK_TICKS(MAB_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .channel_i      (channel_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_level_o   (line_level_o),
    .frame_start_o  (frame_start_o),
    .write_ignored_o(write_ignored_o),
    .busy_res_o     (busy_res_o)
  );

  // ---------------------------------------------------------------------------
  // Line model: our own copy of the universe memory, the frame sequencer and
  // the frame period register. Every accepted beat advances it once and
  // queues the result beat the block must return.
  // ---------------------------------------------------------------------------
  logic [dmxut_pkg::VALUE_W-1:0]  slot_mem [1:SLOTS];
  line_phase_e                    tx_phase;
  int                             phase_ticks;
  int                             bit_idx;
  int                             slot_idx;
  int                             ticks_since_start;
  logic                           line_reg;
  logic [dmxut_pkg::PERIOD_W-1:0] frame_period;
  int                             frames_started;

  line_result_t        pending_results[$];
  int                  failures;

  // Shared knobs for the traffic processes.
  bit                  gaps_enabled;
  bit                  hold_off_request;

  task automatic reset_line_model();
    foreach (slot_mem[i]) slot_mem[i] = '0;
    tx_phase          = ST_IDLE;
    phase_ticks       = 0;
    bit_idx           = 0;
    slot_idx          = 0;
    ticks_since_start = SINCE_SAT;
    line_reg          = 1'b1;
    frame_period      = dmxut_pkg::FRAME_PERIOD_RESET;
    frames_started    = 0;
  endtask

  // Level of the current bit of the current slot; slot 0 is the start code.
  // Memory is read at the bit itself, so late writes still land.
  function automatic logic slot_bit_level();
    logic [dmxut_pkg::VALUE_W-1:0] level_byte;
    level_byte = '0;
    if (bit_idx == 0) return 1'b0;
    if (bit_idx >= 9) return 1'b1;
    if (slot_idx >= 1 && slot_idx <= SLOTS) level_byte = slot_mem[slot_idx];
    return level_byte[bit_idx-1];
  endfunction

  task automatic predict_line_beat(input logic mode,
                                   input logic [dmxut_pkg::CHANNEL_W-1:0] ch,
                                   input logic [dmxut_pkg::VALUE_W-1:0] val);
    line_result_t res;
    logic         in_frame;
    res = '0;
    if (mode == MODE_WRITE) begin
      // Slot 0 and anything past the universe are dropped and flagged.
      if (ch >= 1 && ch <= SLOTS) begin
        slot_mem[ch] = val;
      end else begin
        res.write_ignored = 1'b1;
      end
      res.busy = (tx_phase != ST_IDLE);
    end else begin
      if (ticks_since_start < SINCE_SAT) ticks_since_start++;
      if (tx_phase == ST_IDLE && ticks_since_start >= frame_period) begin
        tx_phase          = ST_BREAK;
        phase_ticks       = 0;
        ticks_since_start = 0;
        res.frame_start   = 1'b1;
        frames_started++;
      end
      // Busy reflects the bit this tick carries, even the last stop bit.
      in_frame = (tx_phase != ST_IDLE);
      case (tx_phase)
        ST_BREAK: begin
          line_reg = 1'b0;
          phase_ticks++;
          if (phase_ticks >= BREAK_LEN) begin
            tx_phase    = ST_MARK;
            phase_ticks = 0;
          end
        end
        ST_MARK: begin
          line_reg = 1'b1;
          phase_ticks++;
          if (phase_ticks >= MAB_LEN) begin
            tx_phase    = ST_DATA;
            phase_ticks = 0;
            slot_idx    = 0;
            bit_idx     = 0;
          end
        end
        ST_DATA: begin
          line_reg = slot_bit_level();
          bit_idx++;
          if (bit_idx >= dmxut_pkg::BITS_PER_SLOT) begin
            bit_idx = 0;
            slot_idx++;
            if (slot_idx > SLOTS) begin
              slot_idx = 0;
              tx_phase = ST_IDLE;
            end
          end
        end
        default: line_reg = 1'b1;
      endcase
      res.busy = in_frame;
    end
    res.line_level = line_reg;
    pending_results.insert(pending_results.size(), res);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, result checking, output stalls and the watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int random_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Compare each result beat against the oldest pending prediction.
  always @(posedge clk_i) begin
    line_result_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (line_level_o !== exp_res.line_level) begin
          $error("line_level: expected %0b, got %0b", exp_res.line_level, line_level_o);
          failures++;
        end
        if (frame_start_o !== exp_res.frame_start) begin
          $error("frame_start: expected %0b, got %0b", exp_res.frame_start, frame_start_o);
          failures++;
        end
        if (write_ignored_o !== exp_res.write_ignored) begin
          $error("write_ignored: expected %0b, got %0b", exp_res.write_ignored,
                 write_ignored_o);
          failures++;
        end
        if (busy_res_o !== exp_res.busy) begin
          $error("busy_res: expected %0b, got %0b", exp_res.busy, busy_res_o);
          failures++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up into its command queue and drops in_ready_o.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left       = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && $urandom_range(2) == 0) begin
        stall_left = random_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Abort when neither channel has moved a beat for too long.
  initial begin
    int cycles_without_beat;
    cycles_without_beat = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        cycles_without_beat = 0;
      end else begin
        cycles_without_beat++;
      end
      if (cycles_without_beat >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then predict it. Valid stays high
  // into the next beat unless a gap is drawn.
  task automatic send_beat(input logic mode, input logic [dmxut_pkg::CHANNEL_W-1:0] ch,
                           input logic [dmxut_pkg::VALUE_W-1:0] val);
    int gap;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    channel_i  <= ch;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_line_beat(mode, ch, val);
    gap = random_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_frame_period(input logic [dmxut_pkg::PERIOD_W-1:0] period);
    cfg_wdata_i <= period;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    frame_period  = period;
  endtask

  // Mostly valid slots; during data often the slot on the wire or the next
  // one, so a write lands on bits still to be sent; some out-of-range slots.
  function automatic logic [dmxut_pkg::CHANNEL_W-1:0] pick_channel();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      if ($urandom_range(1) == 0) return '0;
      return dmxut_pkg::CHANNEL_W'($urandom_range(1023, SLOTS + 1));
    end
    if (r < 45 && tx_phase == ST_DATA && slot_idx >= 1) begin
      return dmxut_pkg::CHANNEL_W'(slot_idx + $urandom_range(1));
    end
    return dmxut_pkg::CHANNEL_W'($urandom_range(SLOTS, 1));
  endfunction

  task automatic send_random_beat(input int write_pct);
    if ($urandom_range(99) < write_pct) begin
      send_beat(MODE_WRITE, pick_channel(), dmxut_pkg::VALUE_W'($urandom_range(255)));
    end else begin
      // Channel and value are don't-care on a tick; toggle them anyway.
      send_beat(MODE_TICK, dmxut_pkg::CHANNEL_W'($urandom_range(1023)),
                dmxut_pkg::VALUE_W'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset, then program the longest period during the clearing pass. The
  // counter starts saturated, so the first tick still opens a frame.
  task automatic test_reset_and_first_frame();
    reset_line_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_frame_period(PERIOD_MAX);
    gaps_enabled = 1'b0;
    send_beat(MODE_WRITE, 10'd0,    8'hFF);  // slot 0 is the start code: drop
    send_beat(MODE_WRITE, 10'd1,    8'hFF);
    send_beat(MODE_WRITE, 10'd512,  8'h80);
    send_beat(MODE_WRITE, 10'd513,  8'hFF);  // one past the universe
    send_beat(MODE_WRITE, 10'd1023, 8'h00);
    send_beat(MODE_WRITE, 10'd2,    8'h00);
    send_beat(MODE_WRITE, 10'd3,    8'hA5);
    send_beat(MODE_TICK,  10'd1023, 8'hFF);  // opens the first frame
    send_beat(MODE_TICK,  10'd0,    8'h00);
    send_beat(MODE_WRITE, 10'd2,    8'h5A);  // write while in break
    send_beat(MODE_WRITE, 10'd0,    8'h00);  // dropped write while busy
    send_beat(MODE_TICK,  10'd512,  8'h5A);
    drain_results();
  endtask

  // Change the period while the first frame is still on the wire: period zero
  // and a period just above a frame both wait for the frame to end, so no
  // new break may start here.
  task automatic test_period_mid_frame();
    set_frame_period('0);
    gaps_enabled = 1'b1;
    repeat (100) send_random_beat(20);
    drain_results();
    set_frame_period(PERIOD_ABOVE_FRAME);
    repeat (100) send_random_beat(20);
    drain_results();
  endtask

  // Mixed writes and ticks under several periods, one stretch without gaps.
  task automatic test_random_traffic();
    logic [dmxut_pkg::PERIOD_W-1:0] periods [4];
    periods[0] = dmxut_pkg::PERIOD_W'($urandom_range(40, 1));
    periods[1] = dmxut_pkg::PERIOD_W'($urandom_range(65535));
    periods[2] = dmxut_pkg::FRAME_PERIOD_RESET;
    periods[3] = PERIOD_MAX;
    for (int seg = 0; seg < 4; seg++) begin
      set_frame_period(periods[seg]);
      gaps_enabled = (seg != 1);
      repeat (230) send_random_beat(40);
      drain_results();
    end
  endtask

  // Hold the receiver off while the sender keeps offering beats back to back.
  task automatic test_output_backpressure();
    gaps_enabled     = 1'b0;
    hold_off_request = 1'b1;
    repeat (40) send_random_beat(40);
    gaps_enabled = 1'b1;
    drain_results();
  endtask

  initial begin
    failures         = 0;
    gaps_enabled     = 1'b0;
    hold_off_request = 1'b0;
    test_reset_and_first_frame();
    test_period_mid_frame();
    test_random_traffic();
    test_output_backpressure();
    if (failures == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
